### src/md5_pkg.sv
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, constants and round functions of the MD5 digest unit.
// ----------------------------------------------------------------------------
`default_nettype none

package md5_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned BlkWords = 16;
  localparam int unsigned PosW     = 6;   // byte position inside a 64-byte block
  localparam int unsigned RndW     = 6;   // round index, 64 rounds
  localparam int unsigned CountW   = 61;  // message length in bytes
  localparam int unsigned WidxW    = 4;
  localparam int unsigned DigestW  = 4 * WordW;

  localparam logic [WordW-1:0] InitA = 32'h67452301;
  localparam logic [WordW-1:0] InitB = 32'hefcdab89;
  localparam logic [WordW-1:0] InitC = 32'h98badcfe;
  localparam logic [WordW-1:0] InitD = 32'h10325476;

  localparam logic [ByteW-1:0] PadByte = 8'h80;
  localparam logic [PosW-1:0]  PosLen  = 6'd56;
  localparam logic [PosW-1:0]  PosLast = 6'd63;
  localparam logic [RndW-1:0]  RndLast = 6'd63;

  localparam logic [WordW-1:0] RoundConst [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] RotAmount [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  typedef enum logic [2:0] {
    StIdle,
    StPad,
    StPrep,
    StComp,
    StFold,
    StDone
  } md5_state_e;

  typedef enum logic [1:0] {
    SelInput,
    SelPad80,
    SelZero,
    SelLength
  } md5_byte_sel_e;

  typedef struct packed {
    logic          byte_we;
    md5_byte_sel_e byte_sel;
    logic          load_work;
    logic          round_en;
    logic          fold;
    logic          finish;
  } md5_cmd_t;

  typedef struct packed {
    logic pos56;
    logic pos63;
    logic rnd_last;
    logic out_free;
  } md5_status_t;

  // Message word used by a given round.
  function automatic logic [WidxW-1:0] md5_widx(input logic [RndW-1:0] rnd);
    logic [RndW+2:0] prod;
    begin
      prod = '0;
      case (rnd[5:4])
        2'd0:    prod = {3'b000, rnd};
        2'd1:    prod = ({3'b000, rnd} * 9'd5) + 9'd1;
        2'd2:    prod = ({3'b000, rnd} * 9'd3) + 9'd5;
        default: prod = {3'b000, rnd} * 9'd7;
      endcase
      return prod[WidxW-1:0];
    end
  endfunction

  function automatic logic [WordW-1:0] md5_f(input logic [1:0] phase,
                                             input logic [WordW-1:0] b,
                                             input logic [WordW-1:0] c,
                                             input logic [WordW-1:0] d);
    logic [WordW-1:0] f;
    begin
      case (phase)
        2'd0:    f = (b & c) | (~b & d);
        2'd1:    f = (b & d) | (c & ~d);
        2'd2:    f = b ^ c ^ d;
        default: f = c ^ (b | ~d);
      endcase
      return f;
    end
  endfunction

  function automatic logic [WordW-1:0] md5_rot_left(input logic [WordW-1:0] x,
                                                    input logic [4:0] n);
    logic [2*WordW-1:0] dbl;
    begin
      dbl = {x, x} << n;
      return dbl[2*WordW-1:WordW];
    end
  endfunction

endpackage

`default_nettype wire

### src/md5_ram.sv
// ----------------------------------------------------------------------------
// md5_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module md5_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### src/md5_ctrl.sv
// ----------------------------------------------------------------------------
// md5_ctrl
// Sequencer of the MD5 unit: byte intake, padding, compression, digest out.
// ----------------------------------------------------------------------------
`default_nettype none

module md5_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic                 in_byte_valid_i,
  input  wire logic                 in_last_i,
  output logic                      in_ready_o,
  output md5_pkg::md5_cmd_t         cmd_o,
  input  wire md5_pkg::md5_status_t status_i
);

  import md5_pkg::*;

  md5_state_e state_q, state_d;
  logic       pad_q, pad_d;     // a padding run is in progress
  logic       first_q, first_d; // next pad byte is the 0x80 marker
  logic       len_q, len_d;     // length bytes have started
  logic       fin_q, fin_d;     // the running compression is the last one
  logic       accept;
  logic       len_now;

  assign accept  = (state_q == StIdle) && in_valid_i;
  assign len_now = !first_q && (len_q || status_i.pos56);

  // Next state and flags.
  always_comb begin
    state_d = state_q;
    pad_d   = pad_q;
    first_d = first_q;
    len_d   = len_q;
    fin_d   = fin_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (in_last_i) begin
            pad_d   = 1'b1;
            first_d = 1'b1;
            len_d   = 1'b0;
            fin_d   = 1'b0;
          end
          if (in_byte_valid_i && status_i.pos63) begin
            state_d = StPrep;
          end else if (in_last_i) begin
            state_d = StPad;
          end
        end
      end
      StPad: begin
        first_d = 1'b0;
        len_d   = len_now;
        if (status_i.pos63) begin
          fin_d   = len_now;
          state_d = StPrep;
        end
      end
      StPrep: state_d = StComp;
      StComp: begin
        if (status_i.rnd_last) begin
          state_d = StFold;
        end
      end
      StFold: begin
        if (fin_q) begin
          state_d = StDone;
        end else if (pad_q) begin
          state_d = StPad;
        end else begin
          state_d = StIdle;
        end
      end
      StDone: begin
        if (status_i.out_free) begin
          pad_d   = 1'b0;
          fin_d   = 1'b0;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o          = '0;
    cmd_o.byte_sel = SelInput;
    in_ready_o     = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o    = 1'b1;
        cmd_o.byte_we = accept && in_byte_valid_i;
      end
      StPad: begin
        cmd_o.byte_we  = 1'b1;
        cmd_o.byte_sel = first_q ? SelPad80 : (len_now ? SelLength : SelZero);
      end
      StPrep: cmd_o.load_work = 1'b1;
      StComp: cmd_o.round_en  = 1'b1;
      StFold: cmd_o.fold      = 1'b1;
      StDone: cmd_o.finish    = status_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      pad_q   <= 1'b0;
      first_q <= 1'b0;
      len_q   <= 1'b0;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      pad_q   <= pad_d;
      first_q <= first_d;
      len_q   <= len_d;
      fin_q   <= fin_d;
    end
  end

endmodule

`default_nettype wire

### src/md5_dp.sv
// ----------------------------------------------------------------------------
// md5_dp
// MD5 datapath: block buffer, byte packer, round unit, chaining words and
// the digest output register.
// ----------------------------------------------------------------------------
`default_nettype none

module md5_dp (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic [md5_pkg::ByteW-1:0]        in_byte_i,
  input  wire md5_pkg::md5_cmd_t                cmd_i,
  output md5_pkg::md5_status_t                  status_o,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic      [md5_pkg::DigestW-1:0]      out_data_o
);

  import md5_pkg::*;

  logic [WordW-1:0]  ha_q, hb_q, hc_q, hd_q;
  logic [WordW-1:0]  wa_q, wb_q, wc_q, wd_q;
  logic [CountW-1:0] count_q;
  logic [PosW-1:0]   pos_q;
  logic [RndW-1:0]   rnd_q;
  logic [RndW-1:0]   rnd_next;
  logic [23:0]       pack_q;
  logic              out_valid_q;
  logic [DigestW-1:0] out_data_q;

  logic [ByteW-1:0]  wr_byte;
  logic [63:0]       bit_len;
  logic              ram_we;
  logic [WordW-1:0]  ram_wdata;
  logic [WidxW-1:0]  ram_raddr;
  logic [WordW-1:0]  msg_word;
  logic [WordW-1:0]  round_sum;
  logic [WordW-1:0]  round_b;

  assign bit_len = {count_q, 3'b000};

  always_comb begin
    case (cmd_i.byte_sel)
      SelInput:  wr_byte = in_byte_i;
      SelPad80:  wr_byte = PadByte;
      SelLength: wr_byte = bit_len[{pos_q[2:0], 3'b000} +: ByteW];
      default:   wr_byte = '0;
    endcase
  end

  // Bytes are gathered little-endian into a word; the fourth byte writes it.
  assign ram_we    = cmd_i.byte_we && (pos_q[1:0] == 2'd3);
  assign ram_wdata = {wr_byte, pack_q};

  assign rnd_next  = rnd_q + 1'b1;
  assign ram_raddr = cmd_i.load_work ? md5_widx('0) : md5_widx(rnd_next);

  md5_ram #(
    .Width (WordW),
    .Depth (BlkWords)
  ) u_blk_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pos_q[PosW-1:2]),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (msg_word)
  );

  assign round_sum = wa_q + md5_f(rnd_q[5:4], wb_q, wc_q, wd_q) + RoundConst[rnd_q] + msg_word;
  assign round_b   = wb_q + md5_rot_left(round_sum, RotAmount[{rnd_q[5:4], rnd_q[1:0]}]);

  assign status_o.pos56    = (pos_q == PosLen);
  assign status_o.pos63    = (pos_q == PosLast);
  assign status_o.rnd_last = (rnd_q == RndLast);
  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.byte_we && (pos_q[1:0] != 2'd3)) begin
      pack_q[{pos_q[1:0], 3'b000} +: ByteW] <= wr_byte;
    end
    if (cmd_i.load_work) begin
      wa_q <= ha_q;
      wb_q <= hb_q;
      wc_q <= hc_q;
      wd_q <= hd_q;
    end else if (cmd_i.round_en) begin
      wa_q <= wd_q;
      wb_q <= round_b;
      wc_q <= wb_q;
      wd_q <= wc_q;
    end
    if (cmd_i.finish) begin
      out_data_q <= {hd_q, hc_q, hb_q, ha_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ha_q        <= InitA;
      hb_q        <= InitB;
      hc_q        <= InitC;
      hd_q        <= InitD;
      count_q     <= '0;
      pos_q       <= '0;
      rnd_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.byte_we) begin
        pos_q <= pos_q + 1'b1;
        if (cmd_i.byte_sel == SelInput) begin
          count_q <= count_q + 1'b1;
        end
      end
      if (cmd_i.load_work) begin
        rnd_q <= '0;
      end else if (cmd_i.round_en) begin
        rnd_q <= rnd_next;
      end
      if (cmd_i.fold) begin
        ha_q <= ha_q + wa_q;
        hb_q <= hb_q + wb_q;
        hc_q <= hc_q + wc_q;
        hd_q <= hd_q + wd_q;
      end
      if (cmd_i.finish) begin
        ha_q        <= InitA;
        hb_q        <= InitB;
        hc_q        <= InitC;
        hd_q        <= InitD;
        count_q     <= '0;
        pos_q       <= '0;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

### src/md5_message_digest_unit.sv
// ----------------------------------------------------------------------------
// md5_message_digest_unit
// MD5 digest of a byte stream, one byte per word, digest at end of message.
// ----------------------------------------------------------------------------
//  channel   direction  carries
//  s_axis    in         tdata: data_byte, tuser: byte_valid, tlast: end_of_message
//  m_axis    out        tdata: digest words A, B, C, D (A lowest)
//
//  A byte word is taken while the unit is idle. The word that fills a 64-byte
//  block is followed by one buffer read setup, 64 rounds of the single
//  round unit, one chaining add. At end of message the pad bytes are written
//  one per cycle (9 to 72 of them) with one or two compressions in between.
//  Reset loads the MD5 initial chaining words; the block buffer needs no clear.
//  A digest waits in the output register; a later digest waits for it.
// ----------------------------------------------------------------------------
`default_nettype none

module md5_message_digest_unit (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  wire logic         s_axis_tuser,   // [0] byte_valid
  input  wire logic         s_axis_tlast,   // end_of_message
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic      [127:0] m_axis_tdata    // [31:0] A, [63:32] B, [95:64] C, [127:96] D
);

  import md5_pkg::*;

  md5_cmd_t    cmd;
  md5_status_t status;

  md5_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid),
    .in_byte_valid_i (s_axis_tuser),
    .in_last_i       (s_axis_tlast),
    .in_ready_o      (s_axis_tready),
    .cmd_o           (cmd),
    .status_i        (status)
  );

  md5_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_byte_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

  // A block is compressed right after its last byte is written.
  a_fill_compress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.byte_we && status.pos63) |=> cmd.load_work)
    else $error("full block not compressed");

  // The chaining add follows the last round.
  a_last_round_fold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.round_en && status.rnd_last) |=> cmd.fold)
    else $error("missing chaining add after last round");

  // Handing off a digest returns the unit to byte intake.
  a_finish_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> (s_axis_tready && m_axis_tvalid))
    else $error("unit not ready after digest");

  // No byte is taken while the round unit is busy.
  a_no_intake_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.round_en || cmd.load_work || cmd.fold) |-> !s_axis_tready)
    else $error("input ready during compression");

endmodule

`default_nettype wire
